// File: sv/baro_pressure_temp_compensation_top_assert.svh
// Assertion macros shared by the compensation pipeline modules.
// Depends on nothing; the module that uses them supplies clk and rst_n.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define BPTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BPTC_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPTC_ASSERT_RST(lbl, prop, msg)

`define BPTC_ASSERT_ALL(lbl, prop, msg)

`endif

`endif

// File: sv/bptc_pkg.sv
// Package for the barometric compensation pipeline: widths, register
// indexes, saturation limits and the structs passed between stages.
package bptc_pkg;

  // Field widths.
  localparam int RAW_W   = 24;
  localparam int CAL_W   = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 22;
  localparam int IDX_W   = 3;

  // Internal widths.
  localparam int DT_W     = RAW_W + 1;          // dT = D2 - C5 * 2^8
  localparam int MULT_W   = DT_W + CAL_W;       // dT times a calibration word
  localparam int DTSQ_W   = 2 * DT_W - 1;       // dT squared
  localparam int DTEMP_W  = 18;                 // dT * C6 / 2^23
  localparam int OFF1_W   = 36;                 // first-order OFF
  localparam int SENS1_W  = 35;                 // first-order SENS
  localparam int T2_W     = 17;                 // dT^2 / 2^31
  localparam int CORR_W   = 40;                 // corrected OFF and SENS

  // Shift amounts of the integer formula.
  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int C5_SHIFT   = 8;
  localparam int C2_SHIFT   = 16;
  localparam int C1_SHIFT   = 15;
  localparam int PROD_SHIFT = 21;
  localparam int PRES_SHIFT = 15;

  // Temperature thresholds in 0.01 degC.
  localparam logic signed [TEMP_W-1:0] TEMP_REF     = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_LOW_OFS = 19'sd1500;

  // Saturation limits.
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [PRES_W-1:0] PRES_MIN = {1'b1, {(PRES_W-1){1'b0}}};
  localparam logic signed [PRES_W-1:0] PRES_MAX = {1'b0, {(PRES_W-1){1'b1}}};

  // Calibration register indexes.
  typedef logic [IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_PRESSURE_SENSITIVITY = 3'd0;
  localparam cfg_idx_t REG_PRESSURE_OFFSET      = 3'd1;
  localparam cfg_idx_t REG_SENSITIVITY_TEMPCO   = 3'd2;
  localparam cfg_idx_t REG_OFFSET_TEMPCO        = 3'd3;
  localparam cfg_idx_t REG_REFERENCE_TEMP       = 3'd4;
  localparam cfg_idx_t REG_TEMP_SLOPE           = 3'd5;

  // Calibration words C1 to C6.
  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order results handed to the correction stages.
  typedef struct packed {
    logic [RAW_W-1:0]          d1;
    logic signed [TEMP_W-1:0]  temp1;
    logic signed [DTEMP_W-1:0] dtemp;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic [T2_W-1:0]           t2;
  } first_t;

  // Corrected values handed to the pressure stages.
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [CORR_W-1:0] off;
    logic signed [CORR_W-1:0] sens;
  } second_t;

endpackage

// File: sv/bptc_first.sv
// First-order stages: dT, the four dT products, then TEMP, OFF, SENS and T2.
// Depends on bptc_pkg and the assertion macro header.
`include "baro_pressure_temp_compensation_top_assert.svh"

module bptc_first (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bptc_pkg::cal_t             cal,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bptc_pkg::RAW_W-1:0] in_d1,
  input  logic [bptc_pkg::RAW_W-1:0] in_d2,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bptc_pkg::first_t           out_data
);
  import bptc_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] v_r, v_nxt, rdy, vin, ld;

  logic [RAW_W-1:0]         s1_d1_r, s2_d1_r;
  logic signed [DT_W-1:0]   s1_dt_r, dt_nxt;
  logic signed [MULT_W-1:0] s2_ptemp_r, s2_poff_r, s2_psens_r;
  logic signed [MULT_W-1:0] ptemp_nxt, poff_nxt, psens_nxt;
  logic signed [DTSQ_W-1:0] s2_dtsq_r, dtsq_nxt;
  logic signed [DT_W-1:0]   c6_s, c4_s, c3_s;
  logic signed [DTEMP_W-1:0] dtemp;
  logic signed [TEMP_W-1:0]  dtemp_x;
  logic signed [OFF1_W-1:0]  off_frac, off_base;
  logic signed [SENS1_W-1:0] sens_frac, sens_base;
  first_t s3_r, s3_nxt;

  // Stage handshake: a stage takes new data when it is empty or drains.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin   = {v_r[NSTG-2:0], in_valid};
    ld    = rdy & vin;
    v_nxt = (rdy & vin) | (~rdy & v_r);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = s3_r;

  // Stage one: temperature difference against the reference reading.
  assign dt_nxt = $signed({1'b0, in_d2}) - $signed({1'b0, cal.c5, {C5_SHIFT{1'b0}}});

  // Stage two: the dT products, one multiplier each.
  assign c6_s      = $signed({{(DT_W-CAL_W){1'b0}}, cal.c6});
  assign c4_s      = $signed({{(DT_W-CAL_W){1'b0}}, cal.c4});
  assign c3_s      = $signed({{(DT_W-CAL_W){1'b0}}, cal.c3});
  assign ptemp_nxt = s1_dt_r * c6_s;
  assign poff_nxt  = s1_dt_r * c4_s;
  assign psens_nxt = s1_dt_r * c3_s;
  assign dtsq_nxt  = s1_dt_r * s1_dt_r;

  // Stage three: shifts and the first-order sums.
  always_comb begin
    dtemp     = $signed(s2_ptemp_r[MULT_W-1:TEMP_SHIFT]);
    dtemp_x   = dtemp;
    off_frac  = $signed(s2_poff_r[MULT_W-1:OFF_SHIFT]);
    off_base  = $signed(OFF1_W'({cal.c2, {C2_SHIFT{1'b0}}}));
    sens_frac = $signed(s2_psens_r[MULT_W-1:SENS_SHIFT]);
    sens_base = $signed(SENS1_W'({cal.c1, {C1_SHIFT{1'b0}}}));

    s3_nxt.d1    = s2_d1_r;
    s3_nxt.dtemp = dtemp;
    s3_nxt.temp1 = dtemp_x + TEMP_REF;
    s3_nxt.off1  = off_base + off_frac;
    s3_nxt.sens1 = sens_base + sens_frac;
    s3_nxt.t2    = s2_dtsq_r[T2_SHIFT+T2_W-1:T2_SHIFT];
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_d1_r <= in_d1;
      s1_dt_r <= dt_nxt;
    end
    if (ld[1]) begin
      s2_d1_r    <= s1_d1_r;
      s2_ptemp_r <= ptemp_nxt;
      s2_poff_r  <= poff_nxt;
      s2_psens_r <= psens_nxt;
      s2_dtsq_r  <= dtsq_nxt;
    end
    if (ld[2]) begin
      s3_r <= s3_nxt;
    end
  end

  // A stalled input means every stage holds an item.
  `BPTC_ASSERT_ALL(a_first_full, !in_ready |-> (&v_r), "first stages stall with a bubble")

endmodule

// File: sv/bptc_second.sv
// Second-order stages: squares of the temperature offsets, then the
// T2, OFF2 and SENS2 corrections and temperature saturation.
// Depends on bptc_pkg and the assertion macro header.
`include "baro_pressure_temp_compensation_top_assert.svh"

module bptc_second (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bptc_pkg::first_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bptc_pkg::second_t out_data
);
  import bptc_pkg::*;

  localparam int NSTG = 2;
  localparam int SQ_W  = 2 * DTEMP_W;
  localparam int SQ2_W = 2 * TEMP_W;

  logic [NSTG-1:0] v_r, v_nxt, rdy, vin, ld;

  logic [RAW_W-1:0]          s1_d1_r;
  logic signed [TEMP_W-1:0]  s1_temp1_r, b_nxt;
  logic signed [OFF1_W-1:0]  s1_off1_r;
  logic signed [SENS1_W-1:0] s1_sens1_r;
  logic [T2_W-1:0]           s1_t2_r;
  logic signed [SQ_W-1:0]    s1_sq_r, sq_nxt;
  logic signed [SQ2_W-1:0]   s1_sq2_r, sq2_nxt;
  logic                      s1_below_ref_r, s1_below_low_r;

  logic [CORR_W-1:0]         sq_w, sq2_w, five_sq, seven_sq2, eleven_sq2, off2, sens2;
  logic signed [CORR_W-1:0]  off1_x, sens1_x, off_nxt, sens_nxt;
  logic signed [TEMP_W:0]    temp1_x, t2_x, tc;
  logic signed [TEMP_W-1:0]  temp_nxt;

  logic [RAW_W-1:0]          s2_d1_r;
  logic signed [TEMP_W-1:0]  s2_temp_r;
  logic signed [CORR_W-1:0]  s2_off_r, s2_sens_r;

  // Stage handshake.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin   = {v_r[NSTG-2:0], in_valid};
    ld    = rdy & vin;
    v_nxt = (rdy & vin) | (~rdy & v_r);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];

  // Stage one: TEMP - 2000 and TEMP + 1500 squared.
  assign b_nxt   = in_data.temp1 + TEMP_LOW_OFS;
  assign sq_nxt  = in_data.dtemp * in_data.dtemp;
  assign sq2_nxt = b_nxt * b_nxt;

  // Stage two: constant multiples by shift and add, then the corrections.
  always_comb begin
    sq_w       = CORR_W'($unsigned(s1_sq_r));
    sq2_w      = CORR_W'($unsigned(s1_sq2_r));
    five_sq    = (sq_w << 2) + sq_w;
    seven_sq2  = (sq2_w << 3) - sq2_w;
    eleven_sq2 = (sq2_w << 3) + (sq2_w << 1) + sq2_w;

    off2  = '0;
    sens2 = '0;
    if (s1_below_ref_r) begin
      off2  = five_sq >> 1;
      sens2 = five_sq >> 2;
    end
    if (s1_below_low_r) begin
      off2  = off2 + seven_sq2;
      sens2 = sens2 + (eleven_sq2 >> 1);
    end

    off1_x   = s1_off1_r;
    sens1_x  = s1_sens1_r;
    off_nxt  = off1_x - $signed(off2);
    sens_nxt = sens1_x - $signed(sens2);

    // Temperature after T2, clamped to the output range.
    temp1_x = s1_temp1_r;
    t2_x    = s1_below_ref_r ? $signed((TEMP_W+1)'(s1_t2_r)) : '0;
    tc      = temp1_x - t2_x;
    if (tc[TEMP_W] != tc[TEMP_W-1]) begin
      temp_nxt = tc[TEMP_W] ? TEMP_MIN : TEMP_MAX;
    end else begin
      temp_nxt = tc[TEMP_W-1:0];
    end
  end

  always_comb begin
    out_data.d1   = s2_d1_r;
    out_data.temp = s2_temp_r;
    out_data.off  = s2_off_r;
    out_data.sens = s2_sens_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s1_d1_r        <= in_data.d1;
      s1_temp1_r     <= in_data.temp1;
      s1_off1_r      <= in_data.off1;
      s1_sens1_r     <= in_data.sens1;
      s1_t2_r        <= in_data.t2;
      s1_sq_r        <= sq_nxt;
      s1_sq2_r       <= sq2_nxt;
      s1_below_ref_r <= in_data.dtemp[DTEMP_W-1];
      s1_below_low_r <= b_nxt[TEMP_W-1];
    end
    if (ld[1]) begin
      s2_d1_r   <= s1_d1_r;
      s2_temp_r <= temp_nxt;
      s2_off_r  <= off_nxt;
      s2_sens_r <= sens_nxt;
    end
  end

  `BPTC_ASSERT_ALL(a_second_full, !in_ready |-> (&v_r), "correction stages stall with a bubble")

  // At or above 20 degC the offset and sensitivity pass unchanged.
  `BPTC_ASSERT_RST(a_no_corr_warm, (v_r[0] && rdy[1] && !s1_below_ref_r) |=> (s2_off_r == $past(s1_off1_r) && s2_sens_r == $past(s1_sens1_r)), "correction applied above reference")

endmodule

// File: sv/bptc_pres.sv
// Pressure stages: D1 * SENS as two partial products, their sum shifted,
// then the offset subtraction, final shift and saturation.
// Depends on bptc_pkg and the assertion macro header.
`include "baro_pressure_temp_compensation_top_assert.svh"

module bptc_pres (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bptc_pkg::second_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bptc_pkg::TEMP_W-1:0] out_temp,
  output logic signed [bptc_pkg::PRES_W-1:0] out_pres
);
  import bptc_pkg::*;

  localparam int NSTG    = 3;
  localparam int SPLIT   = 20;
  localparam int HI_W    = CORR_W - SPLIT;
  localparam int PPLO_W  = RAW_W + SPLIT;
  localparam int PPHI_W  = RAW_W + 1 + HI_W;
  localparam int PROD_W  = 64;
  localparam int Q_W     = PROD_W - PROD_SHIFT;
  localparam int DIFF_W  = Q_W + 1;
  localparam int PFULL_W = DIFF_W - PRES_SHIFT;

  logic [NSTG-1:0] v_r, v_nxt, rdy, vin, ld;

  logic [PPLO_W-1:0]         p1_pplo_r, pplo_nxt;
  logic signed [PPHI_W-1:0]  p1_pphi_r, pphi_nxt;
  logic signed [CORR_W-1:0]  p1_off_r, p2_off_r;
  logic signed [TEMP_W-1:0]  p1_temp_r, p2_temp_r;
  logic signed [HI_W-1:0]    sens_hi;

  logic signed [PROD_W-1:0]  hi_ext, lo_ext, prod;
  logic signed [Q_W-1:0]     p2_q_r, q_nxt;

  logic signed [DIFF_W-1:0]  q_x, off_x, diff;
  logic signed [PFULL_W-1:0] pfull;
  logic signed [PRES_W-1:0]  pres_nxt;

  logic signed [TEMP_W-1:0]  p3_temp_r;
  logic signed [PRES_W-1:0]  p3_pres_r;

  // Stage handshake.
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin   = {v_r[NSTG-2:0], in_valid};
    ld    = rdy & vin;
    v_nxt = (rdy & vin) | (~rdy & v_r);
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NSTG-1];
  assign out_temp  = p3_temp_r;
  assign out_pres  = p3_pres_r;

  // Stage one: SENS split into a low unsigned and a high signed half.
  assign sens_hi  = $signed(in_data.sens[CORR_W-1:SPLIT]);
  assign pplo_nxt = in_data.d1 * in_data.sens[SPLIT-1:0];
  assign pphi_nxt = $signed({1'b0, in_data.d1}) * sens_hi;

  // Stage two: recombine and divide by 2^21.
  always_comb begin
    hi_ext = p1_pphi_r;
    lo_ext = $signed(PROD_W'(p1_pplo_r));
    prod   = (hi_ext <<< SPLIT) + lo_ext;
    q_nxt  = prod[PROD_W-1:PROD_SHIFT];
  end

  // Stage three: subtract OFF, divide by 2^15, clamp.
  always_comb begin
    q_x   = p2_q_r;
    off_x = p2_off_r;
    diff  = q_x - off_x;
    pfull = diff[DIFF_W-1:PRES_SHIFT];
    if ((&pfull[PFULL_W-1:PRES_W-1]) || !(|pfull[PFULL_W-1:PRES_W-1])) begin
      pres_nxt = pfull[PRES_W-1:0];
    end else begin
      pres_nxt = pfull[PFULL_W-1] ? PRES_MIN : PRES_MAX;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1_pplo_r <= pplo_nxt;
      p1_pphi_r <= pphi_nxt;
      p1_off_r  <= in_data.off;
      p1_temp_r <= in_data.temp;
    end
    if (ld[1]) begin
      p2_q_r    <= q_nxt;
      p2_off_r  <= p1_off_r;
      p2_temp_r <= p1_temp_r;
    end
    if (ld[2]) begin
      p3_pres_r <= pres_nxt;
      p3_temp_r <= p2_temp_r;
    end
  end

  `BPTC_ASSERT_ALL(a_pres_full, !in_ready |-> (&v_r), "pressure stages stall with a bubble")

  // The result register drains toward the output without losing an item.
  `BPTC_ASSERT_RST(a_pres_hold, (v_r[2] && !out_ready) |=> v_r[2], "pressure result dropped while stalled")

endmodule

// File: sv/baro_pressure_temp_compensation_top.sv
// Top level of the barometric compensation pipeline: calibration registers
// and the first-order, second-order and pressure stage groups.
// Depends on bptc_pkg, bptc_first, bptc_second and bptc_pres.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_raw_pressure, in_raw_temperature
//   out      output     out_valid / out_ready  out_temp_centi_deg, out_pressure_centi_mbar
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while in_ready is high; each result passes eight register
// stages, one each for dT, the dT products, the first-order sums, the
// squares, the corrections, the partial products of D1 * SENS, their sum, and
// the final pressure with saturation.
// Reset clears every stage valid bit and sets all calibration words to zero.
// A stage holds when its successor is full and stalled, so in_ready falls only when all
// eight stages hold items; cfg_ready is always high.

module baro_pressure_temp_compensation_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bptc_pkg::RAW_W-1:0]        in_raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]        in_raw_temperature,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bptc_pkg::TEMP_W-1:0] out_temp_centi_deg,
  output logic signed [bptc_pkg::PRES_W-1:0] out_pressure_centi_mbar,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bptc_pkg::IDX_W-1:0]        cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]        cfg_data
);
  import bptc_pkg::*;

  cal_t    cal_r, cal_nxt;
  logic    first_valid, first_ready, second_valid, second_ready;
  first_t  first_data;
  second_t second_data;

  // Calibration register writes; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_PRESSURE_SENSITIVITY: cal_nxt.c1 = cfg_data;
        REG_PRESSURE_OFFSET:      cal_nxt.c2 = cfg_data;
        REG_SENSITIVITY_TEMPCO:   cal_nxt.c3 = cfg_data;
        REG_OFFSET_TEMPCO:        cal_nxt.c4 = cfg_data;
        REG_REFERENCE_TEMP:       cal_nxt.c5 = cfg_data;
        REG_TEMP_SLOPE:           cal_nxt.c6 = cfg_data;
        default:                  cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // First-order terms.
  bptc_first u_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_d1     (in_raw_pressure),
    .in_d2     (in_raw_temperature),
    .out_valid (first_valid),
    .out_ready (first_ready),
    .out_data  (first_data)
  );

  // Second-order corrections.
  bptc_second u_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (first_valid),
    .in_ready  (first_ready),
    .in_data   (first_data),
    .out_valid (second_valid),
    .out_ready (second_ready),
    .out_data  (second_data)
  );

  // Pressure and output register.
  bptc_pres u_pres (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (second_valid),
    .in_ready  (second_ready),
    .in_data   (second_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_temp  (out_temp_centi_deg),
    .out_pres  (out_pressure_centi_mbar)
  );

endmodule

// File: tb/sv/tb_baro_pressure_temp_compensation_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for baro_pressure_temp_compensation_top: directed probes, then
// random raw pairs under many calibration settings, checked against an integer predictor.
// Depends on bptc_pkg and the compensation pipeline RTL.

module tb_baro_pressure_temp_compensation_top;
  import bptc_pkg::*;

  localparam int IDLE_PCT        = 37;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CALM_PHASE      = 4;
  localparam int BACKLOG_PHASE   = 5;
  localparam int BACKLOG_HOLD    = 80;
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 100;
  localparam int NUM_PROBES      = 19;

  // Register indexes that decode to nothing; writes there must be ignored.
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  // Calibration selections used by the directed probes.
  localparam logic [1:0] CAL_RESET   = 2'd0;
  localparam logic [1:0] CAL_ONES    = 2'd1;
  localparam logic [1:0] CAL_TYPICAL = 2'd2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } reading_t;

  typedef struct packed {
    logic [1:0]        cal_sel;
    logic [RAW_W-1:0]  d1;
    logic [RAW_W-1:0]  d2;
    logic              typed;
    logic [TEMP_W-1:0] want_temp;
    logic [PRES_W-1:0] want_pres;
  } probe_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [RAW_W-1:0]         in_raw_pressure;
  logic [RAW_W-1:0]         in_raw_temperature;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TEMP_W-1:0] out_temp_centi_deg;
  logic signed [PRES_W-1:0] out_pressure_centi_mbar;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index;
  logic [CAL_W-1:0]         cfg_data;

  cal_t     cal_model;
  reading_t expected_readings[$];
  bit       next_typed;
  reading_t next_want;
  bit       calm;
  int       hold_left;
  int       quiet_cycles;
  int       errors;
  int       items_sent;
  int       readings_checked;
  int       cold_readings;
  int       clipped_readings;
  int       settings_used;

  // At reset every calibration word is zero, so any raw pair reads 20.00 C and 0 mbar.
  probe_t probes [NUM_PROBES] = '{
    '{CAL_RESET,   24'h000000, 24'h000000, 1'b1, 19'd2000, 22'd0},
    '{CAL_RESET,   24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'd2000, 22'd0},
    '{CAL_RESET,   24'hFFFFFF, 24'h000000, 1'b1, 19'd2000, 22'd0},
    '{CAL_RESET,   24'h000000, 24'hFFFFFF, 1'b1, 19'd2000, 22'd0},
    '{CAL_RESET,   24'h800000, 24'h7FFFFF, 1'b1, 19'd2000, 22'd0},
    // Full-scale words: deep cold drives pressure into both saturation limits.
    '{CAL_ONES,    24'h000000, 24'h000000, 1'b0, 19'd0, 22'd0},
    '{CAL_ONES,    24'hFFFFFF, 24'h000000, 1'b0, 19'd0, 22'd0},
    '{CAL_ONES,    24'h000000, 24'hFFFFFF, 1'b0, 19'd0, 22'd0},
    '{CAL_ONES,    24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 22'd0},
    '{CAL_ONES,    24'h800000, 24'hFFFF00, 1'b0, 19'd0, 22'd0},
    '{CAL_ONES,    24'h555555, 24'hAAAAAA, 1'b0, 19'd0, 22'd0},
    // Typical words: the published example and both correction thresholds.
    '{CAL_TYPICAL, 24'd9085466, 24'd8569150, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'd9085466, 24'd8566784, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'd9085466, 24'd8566783, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'd9085466, 24'd7529764, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'd9085466, 24'd7529763, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'h000000, 24'h000000, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'd0, 22'd0},
    '{CAL_TYPICAL, 24'hAAAAAA, 24'h555555, 1'b0, 19'd0, 22'd0}
  };

  cal_t directed_cals [3] = '{
    '0,
    '1,
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312}
  };

  baro_pressure_temp_compensation_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_raw_pressure         (in_raw_pressure),
    .in_raw_temperature      (in_raw_temperature),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_temp_centi_deg      (out_temp_centi_deg),
    .out_pressure_centi_mbar (out_pressure_centi_mbar),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  // Integer compensation with second-order correction; >>> on longint floors.
  function automatic reading_t compensate(cal_t c, logic [RAW_W-1:0] d1,
                                          logic [RAW_W-1:0] d2);
    longint c1, c2, c3, c4, c5, c6;
    longint dt, t1, tc, off, sens, t2, off2, sens2, a, b, p;
    reading_t r;
    c1 = longint'(c.c1);
    c2 = longint'(c.c2);
    c3 = longint'(c.c3);
    c4 = longint'(c.c4);
    c5 = longint'(c.c5);
    c6 = longint'(c.c6);
    dt = longint'(d2) - (c5 <<< C5_SHIFT);
    t1 = longint'(TEMP_REF) + ((dt * c6) >>> TEMP_SHIFT);
    off = (c2 <<< C2_SHIFT) + ((c4 * dt) >>> OFF_SHIFT);
    sens = (c1 <<< C1_SHIFT) + ((c3 * dt) >>> SENS_SHIFT);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    // The thresholds look at the first-order temperature.
    if (t1 < longint'(TEMP_REF)) begin
      a = t1 - longint'(TEMP_REF);
      t2 = (dt * dt) >>> T2_SHIFT;
      off2 = (5 * a * a) >>> 1;
      sens2 = (5 * a * a) >>> 2;
      if (t1 < -longint'(TEMP_LOW_OFS)) begin
        b = t1 + longint'(TEMP_LOW_OFS);
        off2 = off2 + 7 * b * b;
        sens2 = sens2 + ((11 * b * b) >>> 1);
      end
    end
    tc = t1 - t2;
    off = off - off2;
    sens = sens - sens2;
    p = (((longint'(d1) * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
    // Saturate both results to their port widths.
    if (tc < longint'(TEMP_MIN)) tc = longint'(TEMP_MIN);
    if (tc > longint'(TEMP_MAX)) tc = longint'(TEMP_MAX);
    if (p < longint'(PRES_MIN)) p = longint'(PRES_MIN);
    if (p > longint'(PRES_MAX)) p = longint'(PRES_MAX);
    r.temp = tc[TEMP_W-1:0];
    r.pres = p[PRES_W-1:0];
    return r;
  endfunction

  function automatic logic [CAL_W-1:0] rand_cal_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CAL_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    logic [31:0] w;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    w = $urandom;
    return w[RAW_W-1:0];
  endfunction

  // Temperature reading: mostly spread around the reference point at every scale,
  // so all three correction ranges are reached, plus full-range noise.
  function automatic logic [RAW_W-1:0] rand_raw_temp(cal_t c);
    longint pick;
    longint ofs;
    int k;
    if ($urandom_range(0, 99) < 25) return rand_raw();
    k = $urandom_range(0, 23);
    ofs = longint'($urandom_range(0, (1 << k) - 1));
    if ($urandom_range(0, 1) == 1) ofs = -ofs;
    pick = (longint'(c.c5) <<< C5_SHIFT) + ofs;
    if (pick < 0) pick = 0;
    if (pick > longint'({RAW_W{1'b1}})) pick = longint'({RAW_W{1'b1}});
    return pick[RAW_W-1:0];
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Scoreboard: check the finished reading first, then record the new item.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      readings_checked++;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: reading with none expected, expected nothing, got temp %0d pressure %0d",
                   $time, out_temp_centi_deg, out_pressure_centi_mbar);
      end else begin
        want = expected_readings.pop_front();
        if (want.temp < TEMP_REF) cold_readings++;
        if (want.pres == PRES_MAX || want.pres == PRES_MIN) clipped_readings++;
        if (out_temp_centi_deg !== want.temp) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: temperature mismatch, expected %0d, got %0d",
                     $time, want.temp, out_temp_centi_deg);
        end
        if (out_pressure_centi_mbar !== want.pres) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: pressure mismatch, expected %0d, got %0d",
                     $time, want.pres, out_pressure_centi_mbar);
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (next_typed)
        expected_readings.push_back(next_want);
      else
        expected_readings.push_back(compensate(cal_model, in_raw_pressure,
                                               in_raw_temperature));
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one item, with random idle cycles in front unless the run is calm.
  task automatic send_item(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2, bit typed,
                           reading_t want);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    next_typed = typed;
    next_want = want;
    in_valid <= 1'b1;
    in_raw_pressure <= d1;
    in_raw_temperature <= d2;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering, wait for every outstanding reading, then let the pipe settle.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CAL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PRESSURE_SENSITIVITY: cal_model.c1 = data;
      REG_PRESSURE_OFFSET:      cal_model.c2 = data;
      REG_SENSITIVITY_TEMPCO:   cal_model.c3 = data;
      REG_OFFSET_TEMPCO:        cal_model.c4 = data;
      REG_REFERENCE_TEMP:       cal_model.c5 = data;
      REG_TEMP_SLOPE:           cal_model.c6 = data;
      default: ;
    endcase
  endtask

  // Load all six words, then hit the undecoded indexes with junk.
  task automatic program_cal(cal_t c);
    write_reg(REG_PRESSURE_SENSITIVITY, c.c1);
    write_reg(REG_PRESSURE_OFFSET, c.c2);
    write_reg(REG_SENSITIVITY_TEMPCO, c.c3);
    write_reg(REG_OFFSET_TEMPCO, c.c4);
    write_reg(REG_REFERENCE_TEMP, c.c5);
    write_reg(REG_TEMP_SLOPE, c.c6);
    write_reg(REG_SPARE_LO, rand_cal_word());
    write_reg(REG_SPARE_HI, rand_cal_word());
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Main sequence.
  initial begin
    logic [1:0] cur_sel;
    cal_t       c;
    reading_t   want;
    logic [RAW_W-1:0] d2;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cal_model = '0;
    next_typed = 1'b0;
    next_want = '0;
    calm = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    errors = 0;
    items_sent = 0;
    readings_checked = 0;
    cold_readings = 0;
    clipped_readings = 0;
    settings_used = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed probes; a new calibration is loaded only with the pipe empty.
    cur_sel = CAL_RESET;
    for (int i = 0; i < NUM_PROBES; i++) begin
      if (probes[i].cal_sel != cur_sel) begin
        drain_pipe();
        program_cal(directed_cals[probes[i].cal_sel]);
        cur_sel = probes[i].cal_sel;
      end
      want.temp = probes[i].want_temp;
      want.pres = probes[i].want_pres;
      send_item(probes[i].d1, probes[i].d2, probes[i].typed, want);
    end

    // Random phases: extreme and typical settings first, then random words.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe();
      if (ph == 0) begin
        c = '0;
      end else if (ph == 1) begin
        c = '1;
      end else if (ph == 2) begin
        c = directed_cals[CAL_TYPICAL];
      end else begin
        c.c1 = rand_cal_word();
        c.c2 = rand_cal_word();
        c.c3 = rand_cal_word();
        c.c4 = rand_cal_word();
        c.c5 = rand_cal_word();
        c.c6 = rand_cal_word();
      end
      calm = (ph == CALM_PHASE) || (ph == BACKLOG_PHASE);
      // Hold the result side off so the pipe fills and stalls the input.
      if (ph == BACKLOG_PHASE) hold_left = BACKLOG_HOLD;
      program_cal(c);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        d2 = rand_raw_temp(cal_model);
        send_item(rand_raw(), d2, 1'b0, '0);
      end
    end
    drain_pipe();
    calm = 1'b0;

    $display("Sent %0d raw pairs under %0d calibration settings and checked %0d readings;",
             items_sent, settings_used, readings_checked);
    $display("%0d readings were below 20 C and %0d had pressure clipped; %0d problems seen.",
             cold_readings, clipped_readings, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/bptc_pkg.sv
sv/bptc_first.sv
sv/bptc_second.sv
sv/bptc_pres.sv
sv/baro_pressure_temp_compensation_top.sv
tb/sv/tb_baro_pressure_temp_compensation_top.sv
